// ===== hdl/mcv_pkg.sv =====
`default_nettype none

package mcv_pkg;

  localparam int NUM_SIDES   = 6;
  localparam int SIDE_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_ENTRIES = 65536;

  // result fields
  localparam int RATIO_W = 18;
  localparam int COUNT_W = 17;
  localparam int SUM_W   = 34;

  // entry arithmetic
  localparam int S_W        = SIDE_W + 3;                // sum of six sides
  localparam int Q_W        = 2 * SIDE_W + 3;            // sum of six squares
  localparam int DIG_W      = 4;                         // multiplier digit
  localparam int MUL_DIGITS = (S_W + DIG_W - 1) / DIG_W;
  localparam int MPL_W      = MUL_DIGITS * DIG_W;
  localparam int PROD_W     = 2 * S_W;
  // 6*Q - S*S is a sum of 15 squared pair differences, at most 9 * max^2
  localparam int D_W        = 2 * SIDE_W + 4;
  localparam int RAD_W      = D_W + 2 * FRAC_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 1;

  localparam int IN_TDATA_W  = NUM_SIDES * SIDE_W;
  localparam int OUT_TDATA_W = ((RATIO_W + COUNT_W + 7) / 8) * 8;

  typedef logic [SIDE_W-1:0] side_t;

endpackage

`default_nettype wire

// ===== hdl/mean_coefficient_of_variation.sv =====
// Channel | Dir | tdata (low bit up)              | tuser              | tlast
// --------+-----+----------------------------------+--------------------+-----------
// in_     | in  | side_0 .. side_5, 32 bits each   | entry_failed       | last_entry
// out_    | out | mean_ratio[17:0], entries_used   | no_entries,        | -
//         |     | [34:18], zero pad to 40 bits     | zero_mean_seen     |
//
// A counted entry runs six side squarings (load, nine radix-16 digits, add),
// a squaring of the sum, a square root, a divide and control states. An
// all-zero entry skips the root and the divide, and a failed or overflow
// entry skips all arithmetic. A last item adds a mean divide (none when
// nothing was counted) and an emit step that waits for the output register.
// One entry is in flight at a time; in_tready is high only between entries.
// A waiting result holds in the output register while the next entries run;
// a new result waits for it to be taken. Reset (rst_n low, synchronous)
// clears the running sum, count and flag and empties the output register.
`default_nettype none

module mean_coefficient_of_variation
  import mcv_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // side_0 .. side_5
  input  wire logic                   in_tuser,   // entry_failed
  input  wire logic                   in_tlast,   // last_entry
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // mean_ratio, entries_used, pad
  output logic [1:0]                  out_tuser   // no_entries, zero_mean_seen
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOAD = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_DIFF = 4'd4;
  localparam logic [3:0] ST_ROOT = 4'd5;
  localparam logic [3:0] ST_DIVR = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_MEAN = 4'd8;
  localparam logic [3:0] ST_EMIT = 4'd9;

  localparam int DCNT_W = $clog2(MUL_DIGITS);
  localparam int SCNT_W = $clog2(NUM_SIDES + 1);

  logic [3:0]         state_r,    state_nxt;
  side_t              side_r [NUM_SIDES];
  side_t              side_nxt [NUM_SIDES];
  logic               last_r,     last_nxt;
  logic [SCNT_W-1:0]  scnt_r,     scnt_nxt;
  logic [DCNT_W-1:0]  dcnt_r,     dcnt_nxt;
  logic               sq_s_r,     sq_s_nxt;
  logic [S_W-1:0]     mcand_r,    mcand_nxt;
  logic [MPL_W-1:0]   mplier_r,   mplier_nxt;
  logic [PROD_W-1:0]  acc_r,      acc_nxt;
  logic [S_W-1:0]     s_r,        s_nxt;
  logic [Q_W-1:0]     q_r,        q_nxt;
  logic [D_W-1:0]     d_r,        d_nxt;
  logic [SUM_W-1:0]   sum_r,      sum_nxt;
  logic [COUNT_W-1:0] count_r,    count_nxt;
  logic               zm_r,       zm_nxt;
  logic [RATIO_W-1:0] mean_r,     mean_nxt;
  logic               ovalid_r,   ovalid_nxt;
  logic [RATIO_W-1:0] omean_r,    omean_nxt;
  logic [COUNT_W-1:0] ocount_r,   ocount_nxt;
  logic               onone_r,    onone_nxt;
  logic               ozm_r,      ozm_nxt;

  logic [S_W+DIG_W-1:0] pp;
  logic [PROD_W-1:0]    q6;
  logic [PROD_W-1:0]    dfull;
  logic                 in_acc;
  logic                 use_entry;

  logic                 sqrt_start;
  logic                 sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;
  logic                 div_start;
  logic                 div_done;
  logic [ROOT_W-1:0]    div_dvd;
  logic [S_W-1:0]       div_dvs;
  logic [RATIO_W-1:0]   div_quo;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign use_entry = !in_tuser && (count_r < COUNT_W'(MAX_ENTRIES));

  assign pp    = mcand_r * mplier_r[MPL_W-1 -: DIG_W];
  assign q6    = PROD_W'({q_r, 2'b00}) + PROD_W'({q_r, 1'b0});
  assign dfull = q6 - acc_r;

  assign sqrt_start = (state_r == ST_DIFF) && (s_r != '0);
  assign div_start  = ((state_r == ST_ROOT) && sqrt_done) ||
                      ((state_r == ST_FIN) && last_r && (count_r != '0));
  assign div_dvd    = (state_r == ST_FIN) ? ROOT_W'(sum_r) : sqrt_root;
  assign div_dvs    = (state_r == ST_FIN) ? S_W'(count_r) : s_r;

  always_comb begin
    state_nxt  = state_r;
    side_nxt   = side_r;
    last_nxt   = last_r;
    scnt_nxt   = scnt_r;
    dcnt_nxt   = dcnt_r;
    sq_s_nxt   = sq_s_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    s_nxt      = s_r;
    q_nxt      = q_r;
    d_nxt      = d_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    zm_nxt     = zm_r;
    mean_nxt   = mean_r;
    ovalid_nxt = ovalid_r && !out_tready;
    omean_nxt  = omean_r;
    ocount_nxt = ocount_r;
    onone_nxt  = onone_r;
    ozm_nxt    = ozm_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < NUM_SIDES; i++) begin
            side_nxt[i] = in_tdata[i*SIDE_W +: SIDE_W];
          end
          last_nxt  = in_tlast;
          scnt_nxt  = '0;
          sq_s_nxt  = 1'b0;
          s_nxt     = '0;
          q_nxt     = '0;
          state_nxt = use_entry ? ST_LOAD : ST_FIN;
        end
      end
      ST_LOAD: begin
        mcand_nxt  = S_W'(side_r[0]);
        mplier_nxt = MPL_W'(side_r[0]);
        s_nxt      = s_r + S_W'(side_r[0]);
        acc_nxt    = '0;
        dcnt_nxt   = '0;
        scnt_nxt   = scnt_r + 1'b1;
        // advance the side line so the next side sits at the head
        for (int i = 0; i < NUM_SIDES - 1; i++) begin
          side_nxt[i] = side_r[i+1];
        end
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        acc_nxt    = {acc_r[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}} + PROD_W'(pp);
        mplier_nxt = {mplier_r[MPL_W-DIG_W-1:0], {DIG_W{1'b0}}};
        dcnt_nxt   = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(MUL_DIGITS - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (sq_s_r) begin
          d_nxt     = dfull[D_W-1:0];
          state_nxt = ST_DIFF;
        end else begin
          q_nxt = q_r + Q_W'(acc_r);
          if (scnt_r == SCNT_W'(NUM_SIDES)) begin
            mcand_nxt  = s_r;
            mplier_nxt = MPL_W'(s_r);
            acc_nxt    = '0;
            dcnt_nxt   = '0;
            sq_s_nxt   = 1'b1;
            state_nxt  = ST_MUL;
          end else begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_DIFF: begin
        if (s_r == '0) begin
          // all sides zero: count it, add nothing
          zm_nxt    = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_nxt = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (div_done) begin
          sum_nxt   = sum_r + SUM_W'(div_quo);
          count_nxt = count_r + 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (count_r == '0) begin
          mean_nxt  = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          mean_nxt  = div_quo;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          omean_nxt  = mean_r;
          ocount_nxt = count_r;
          onone_nxt  = (count_r == '0);
          ozm_nxt    = zm_r;
          sum_nxt    = '0;
          count_nxt  = '0;
          zm_nxt     = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      sum_r    <= '0;
      count_r  <= '0;
      zm_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      zm_r     <= zm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r   <= side_nxt;
    last_r   <= last_nxt;
    scnt_r   <= scnt_nxt;
    dcnt_r   <= dcnt_nxt;
    sq_s_r   <= sq_s_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
    s_r      <= s_nxt;
    q_r      <= q_nxt;
    d_r      <= d_nxt;
    mean_r   <= mean_nxt;
    omean_r  <= omean_nxt;
    ocount_r <= ocount_nxt;
    onone_r  <= onone_nxt;
    ozm_r    <= ozm_nxt;
  end

  mcv_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   ({d_r, {(2*FRAC_BITS){1'b0}}}),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  mcv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RATIO_W-COUNT_W){1'b0}}, ocount_r, omean_r};
  assign out_tuser  = {ozm_r, onone_r};

  a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_ROOT)
    else $error("root finished outside the root wait state");

  a_div_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIVR || state_r == ST_MEAN))
    else $error("divide finished outside a divide wait state");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_ENTRIES))
    else $error("entry count above its limit");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[RATIO_W+COUNT_W-1:RATIO_W] == '0 && out_tdata[RATIO_W-1:0] == '0))
    else $error("empty result carries a count or a mean");

endmodule

`default_nettype wire

// ===== hdl/mcv_sqrt.sv =====
`default_nettype none

// Integer square root, one result bit per cycle (two radicand bits shifted in).
module mcv_sqrt
  import mcv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  rad,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;

  always_comb begin
    rem_sh   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial    = (REM_W+2)'({root_r, 2'b01});
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = REM_W'(rem_sh - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(rem_sh);
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== hdl/mcv_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is known to fit
// in RATIO_W bits, so the upper dividend bits start out as the remainder.
module mcv_div
  import mcv_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [ROOT_W-1:0]  dividend,
  input  wire logic [S_W-1:0]     divisor,
  output logic                    done,
  output logic [RATIO_W-1:0]      quo
);

  localparam int CNT_W = $clog2(RATIO_W);
  localparam int HI_W  = ROOT_W - RATIO_W;

  logic [S_W-1:0]     rem_r,  rem_nxt;
  logic [S_W-1:0]     dvs_r,  dvs_nxt;
  logic [RATIO_W-1:0] low_r,  low_nxt;
  logic [CNT_W-1:0]   cnt_r,  cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  logic [S_W:0]       rem_sh;

  always_comb begin
    rem_sh   = {rem_r, low_r[RATIO_W-1]};
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    low_nxt  = low_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = S_W'(dividend[ROOT_W-1 -: HI_W]);
      low_nxt  = dividend[RATIO_W-1:0];
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift dividend bits out the top, quotient bits in at the bottom
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = S_W'(rem_sh - {1'b0, dvs_r});
        low_nxt = {low_r[RATIO_W-2:0], 1'b1};
      end else begin
        rem_nxt = S_W'(rem_sh);
        low_nxt = {low_r[RATIO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(RATIO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    low_r <= low_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = low_r;

endmodule

`default_nettype wire

// ===== dv/mean_coefficient_of_variation_tb.sv =====
`default_nettype none

module mean_coefficient_of_variation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcv_pkg::*;

  localparam int  CYCLE_LIMIT  = 3_000_000;
  localparam int  DRAIN_CYCLES = 400;
  localparam int  RANDOM_ITEMS = 2000;
  localparam side_t SMAX       = '1;

  typedef enum logic [1:0] {
    PH_FREE    = 2'd0,
    PH_SRC_GAP = 2'd1,
    PH_DST_GAP = 2'd2,
    PH_BOTH    = 2'd3
  } idle_phase_e;

  typedef struct packed {
    logic [IN_TDATA_W-1:0] sides;
    logic                  failed;
    logic                  last;
    idle_phase_e           phase;
  } entry_t;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [COUNT_W-1:0] count;
    logic               no_entries;
    logic               zero_mean;
  } mean_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  entry_t       pending_entries[$];
  mean_result_t expected_means[$];
  entry_t       entry_on_bus;

  // running state of the batch being accumulated
  logic [SUM_W-1:0]   acc_ratio_sum = '0;
  logic [COUNT_W-1:0] acc_count = '0;
  logic               acc_zero_mean = 1'b0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  mean_coefficient_of_variation i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // floor(isqrt((6Q - S^2) << 2F) / S), all in exact integers
  function automatic logic [RATIO_W-1:0] cv_ratio(input logic [IN_TDATA_W-1:0] sides);
    logic [127:0] x, s, q, d, rad, c, sq, root, quo;
    int i;
    s = '0;
    q = '0;
    root = '0;
    for (i = 0; i < NUM_SIDES; i++) begin
      x = {96'b0, sides[i*SIDE_W +: SIDE_W]};
      s = s + x;
      q = q + x * x;
    end
    d = (q << 2) + (q << 1) - s * s;
    rad = d << (2 * FRAC_BITS);
    for (i = 63; i >= 0; i--) begin
      c = root | (128'd1 << i);
      sq = c * c;
      if (sq <= rad) root = c;
    end
    quo = root / s;
    return quo[RATIO_W-1:0];
  endfunction

  task automatic accumulate_entry(input entry_t e);
    mean_result_t r;
    logic [SUM_W-1:0] mean;
    if (!e.failed && acc_count < MAX_ENTRIES) begin
      if (e.sides == '0) acc_zero_mean = 1'b1;
      else acc_ratio_sum = acc_ratio_sum + cv_ratio(e.sides);
      acc_count = acc_count + 1'b1;
    end
    if (e.last) begin
      if (acc_count == 0) begin
        r.ratio = '0;
        r.no_entries = 1'b1;
      end else begin
        mean = acc_ratio_sum / acc_count;
        r.ratio = mean[RATIO_W-1:0];
        r.no_entries = 1'b0;
      end
      r.count = acc_count;
      r.zero_mean = acc_zero_mean;
      expected_means.push_back(r);
      acc_ratio_sum = '0;
      acc_count = '0;
      acc_zero_mean = 1'b0;
    end
  endtask

  function automatic side_t rand_side(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 255);
      2: return SMAX - $urandom_range(0, 1000);
      3: return '0;
      default: return SMAX;
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] rand_sides();
    logic [IN_TDATA_W-1:0] v;
    side_t one;
    int pick, i;
    v = '0;
    pick = $urandom_range(0, 99);
    one = $urandom();
    for (i = 0; i < NUM_SIDES; i++) begin
      if (pick < 35) v[i*SIDE_W +: SIDE_W] = rand_side(0);
      else if (pick < 50) v[i*SIDE_W +: SIDE_W] = rand_side(1);
      else if (pick < 60) v[i*SIDE_W +: SIDE_W] = one;
      else if (pick < 74) v[i*SIDE_W +: SIDE_W] = rand_side(2);
      else if (pick < 80) v[i*SIDE_W +: SIDE_W] = '0;
      else v[i*SIDE_W +: SIDE_W] = rand_side($urandom_range(0, 4));
    end
    // one dominant side over near-zero others
    if (pick >= 60 && pick < 68) begin
      for (i = 0; i < NUM_SIDES; i++) v[i*SIDE_W +: SIDE_W] = rand_side(1);
      v[$urandom_range(0, NUM_SIDES - 1)*SIDE_W +: SIDE_W] = rand_side(2);
    end
    return v;
  endfunction

  task automatic add_entry(input logic [IN_TDATA_W-1:0] sides, input logic failed,
                           input logic last, input idle_phase_e phase);
    entry_t e;
    e.sides = sides;
    e.failed = failed;
    e.last = last;
    e.phase = phase;
    pending_entries.push_back(e);
  endtask

  // driver: present the next entry once the previous transaction is done
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) accumulate_entry(entry_on_bus);
      if (!in_tvalid || in_tready) begin
        if (pending_entries.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          entry_on_bus = pending_entries.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= entry_on_bus.sides;
          in_tuser  <= entry_on_bus.failed;
          in_tlast  <= entry_on_bus.last;
          case (entry_on_bus.phase)
            PH_SRC_GAP: begin sender_idle_pct <= 81; recv_stall_pct <= 0;  end
            PH_DST_GAP: begin sender_idle_pct <= 0;  recv_stall_pct <= 81; end
            PH_BOTH:    begin sender_idle_pct <= 24; recv_stall_pct <= 24; end
            default:    begin sender_idle_pct <= 0;  recv_stall_pct <= 0;  end
          endcase
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    mean_result_t exp_r, got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.ratio      = out_tdata[RATIO_W-1:0];
        got.count      = out_tdata[RATIO_W +: COUNT_W];
        got.no_entries = out_tuser[0];
        got.zero_mean  = out_tuser[1];
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ratio=%0d count=%0d no_entries=%0b zero_mean=%0b",
                     got.ratio, got.count, got.no_entries, got.zero_mean);
        end else begin
          exp_r = expected_means.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp/got: ratio %0d/%0d count %0d/%0d empty %0b/%0b zm %0b/%0b",
                       exp_r.ratio, got.ratio, exp_r.count, got.count,
                       exp_r.no_entries, got.no_entries, exp_r.zero_mean, got.zero_mean);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int n, batch_len, k, sel;
    idle_phase_e ph;

    // zero mean, failed-only batch, equal sides, largest ratio
    add_entry('0, 1'b0, 1'b1, PH_FREE);
    add_entry({6{SMAX}}, 1'b1, 1'b1, PH_FREE);
    add_entry({6{SMAX}}, 1'b0, 1'b1, PH_FREE);
    add_entry({160'b0, SMAX}, 1'b0, 1'b1, PH_FREE);
    add_entry({SMAX, 160'b0}, 1'b0, 1'b1, PH_FREE);
    add_entry({{5{SMAX}}, 32'b0}, 1'b0, 1'b1, PH_FREE);
    add_entry({160'b0, 32'd1}, 1'b0, 1'b1, PH_FREE);
    // mixed batch ending on a failed entry
    add_entry(rand_sides(), 1'b0, 1'b0, PH_FREE);
    add_entry('0, 1'b0, 1'b0, PH_FREE);
    add_entry({6{32'h5555_5555}}, 1'b1, 1'b0, PH_FREE);
    add_entry({SMAX, 32'b0, SMAX, 32'b0, SMAX, 32'b0}, 1'b0, 1'b0, PH_FREE);
    add_entry({6{32'hAAAA_AAAA}}, 1'b1, 1'b1, PH_FREE);
    // three largest ratios average to the largest
    for (k = 0; k < 3; k++)
      add_entry({128'b0, SMAX, 32'b0}, 1'b0, k == 2, PH_FREE);
    add_entry(rand_sides(), 1'b0, 1'b1, PH_FREE);
    add_entry(rand_sides(), 1'b0, 1'b1, PH_FREE);
    add_entry(rand_sides(), 1'b1, 1'b0, PH_FREE);
    add_entry({6{SMAX}}, 1'b0, 1'b1, PH_FREE);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 80) batch_len = $urandom_range(1, 12);
      else if (sel < 95) batch_len = $urandom_range(13, 40);
      else batch_len = $urandom_range(41, 100);
      ph = idle_phase_e'((n * 4) / RANDOM_ITEMS);
      for (k = 0; k < batch_len; k++)
        add_entry(rand_sides(), $urandom_range(0, 99) < 12, k == batch_len - 1, ph);
      n += batch_len;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_entries.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
